// ===== hw/rtl/dto_pkg.sv =====
// Shared types, constants and table functions for the table oscillator.
package dto_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ROM_BITS    = 6;
  localparam int FRAC_W      = 16;

  localparam int MODE_FM_BIT = 0;
  localparam int MODE_AM_BIT = 1;

  typedef enum logic [1:0] {
    CFG_AMPLITUDE  = 2'd0,
    CFG_PHASE_STEP = 2'd1,
    CFG_MOD_MODE   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ROM_BITS-1:0]  idx0;
    logic [ROM_BITS-1:0]  idx1;
    logic [FRAC_W-1:0]    frac;
    logic                 am_en;
    logic signed [15:0]   am_gain;
    logic                 block_end;
  } item_t;

  localparam logic signed [15:0] QUARTER_WAVE [17] = '{
    16'sd32767, 16'sd32610, 16'sd32138, 16'sd31357, 16'sd30274, 16'sd28899,
    16'sd27246, 16'sd25330, 16'sd23170, 16'sd20788, 16'sd18205, 16'sd15447,
    16'sd12540, 16'sd9512,  16'sd6393,  16'sd3212,  16'sd0
  };

  localparam logic signed [18:0] SAT_HI = 19'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [18:0] SAT_LO = -SAT_HI - 19'sd1;

  function automatic logic signed [15:0] rom_entry(input logic [ROM_BITS-1:0] i);
    logic [5:0]         k;
    logic signed [15:0] r;
    if (i <= 6'd16) begin
      k = i;
      r = QUARTER_WAVE[k[4:0]];
    end else if (i < 6'd32) begin
      k = 6'd32 - i;
      r = -QUARTER_WAVE[k[4:0]];
    end else if (i == 6'd32) begin
      k = 6'd0;
      r = -16'sd32767 - 16'sd1;
    end else if (i <= 6'd48) begin
      k = i - 6'd32;
      r = -QUARTER_WAVE[k[4:0]];
    end else begin
      k = 6'd0 - i;
      r = QUARTER_WAVE[k[4:0]];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat_sample(input logic signed [18:0] v);
    logic signed [18:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return r[15:0];
  endfunction

endpackage

// ===== hw/rtl/dto_front.sv =====
// Front end: configuration registers, phase accumulator and table address split.
module dto_front import dto_pkg::*; #(
  parameter int TABLE_BITS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               req_valid,
  input  logic               full,
  input  logic signed [31:0] freq_offset,
  input  logic signed [15:0] am_gain,
  input  logic               block_end,
  output logic               push,
  output item_t              item,
  output logic signed [15:0] amplitude
);

  logic [31:0]           phase_step;
  logic [1:0]            modulation_mode;
  logic [31:0]           phase;
  logic [31:0]           phase_next;
  logic [TABLE_BITS-1:0] x0;
  logic [TABLE_BITS-1:0] x1;
  logic [31:0]           x0_wide;
  logic [31:0]           x1_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude       <= '0;
      phase_step      <= '0;
      modulation_mode <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_AMPLITUDE:  amplitude       <= cfg_data[15:0];
        CFG_PHASE_STEP: phase_step      <= cfg_data;
        CFG_MOD_MODE:   modulation_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign push = req_valid && !full;

  assign x0      = phase[31 -: TABLE_BITS];
  assign x1      = x0 + TABLE_BITS'(1);
  assign x0_wide = 32'(x0) << ROM_BITS;
  assign x1_wide = 32'(x1) << ROM_BITS;

  always_comb begin
    item.idx0      = x0_wide[TABLE_BITS +: ROM_BITS];
    item.idx1      = x1_wide[TABLE_BITS +: ROM_BITS];
    item.frac      = phase[31-TABLE_BITS -: FRAC_W];
    item.am_en     = modulation_mode[MODE_AM_BIT];
    item.am_gain   = am_gain;
    item.block_end = block_end;
    phase_next     = phase + phase_step;
    if (modulation_mode[MODE_FM_BIT]) begin
      phase_next = phase_next + freq_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (push) begin
      phase <= phase_next;
    end
  end

endmodule

// ===== hw/rtl/dto_queue.sv =====
// Four-entry queue between the front end and the arithmetic back end.
module dto_queue import dto_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  head_valid,
  output item_t head_item
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full       = count == (AW+1)'(DEPTH);
  assign head_valid = count != '0;
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH)) else $error("queue count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("pop from empty queue");
  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");
`endif

endmodule

// ===== hw/rtl/dto_back.sv =====
// Back end: table read, interpolation, amplitude and modulation scaling.
module dto_back import dto_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  item_t              head_item,
  input  logic signed [15:0] amplitude,
  output logic               pop,
  output logic               smp_valid,
  input  logic               smp_stall,
  output logic signed [15:0] sample,
  output logic               block_end_out
);

  logic adv;
  logic v1, v2, v3, v4, v5, v6;

  logic signed [15:0] y0_1, y1_1;
  logic [15:0]        frac_1;
  logic signed [15:0] y0_2;
  logic signed [33:0] d_2;
  logic signed [17:0] y_3;
  logic signed [33:0] p_4;
  logic signed [15:0] s_5;
  logic signed [31:0] q_6;
  logic signed [15:0] s_6;

  logic               am_en_1, am_en_2, am_en_3, am_en_4, am_en_5, am_en_6;
  logic signed [15:0] gain_1, gain_2, gain_3, gain_4, gain_5;
  logic               be_1, be_2, be_3, be_4, be_5, be_6;

  logic signed [16:0] diff;

  assign adv  = !smp_valid || !smp_stall;
  assign pop  = adv && head_valid;
  assign diff = {y1_1[15], y1_1} - {y0_1[15], y0_1};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      smp_valid <= 1'b0;
    end else if (adv) begin
      v1 <= head_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      smp_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      y0_1    <= rom_entry(head_item.idx0);
      y1_1    <= rom_entry(head_item.idx1);
      frac_1  <= head_item.frac;
      am_en_1 <= head_item.am_en;
      gain_1  <= head_item.am_gain;
      be_1    <= head_item.block_end;

      y0_2    <= y0_1;
      d_2     <= diff * $signed({1'b0, frac_1});
      am_en_2 <= am_en_1;
      gain_2  <= gain_1;
      be_2    <= be_1;

      y_3     <= {{2{y0_2[15]}}, y0_2} + d_2[33:16];
      am_en_3 <= am_en_2;
      gain_3  <= gain_2;
      be_3    <= be_2;

      p_4     <= y_3 * amplitude;
      am_en_4 <= am_en_3;
      gain_4  <= gain_3;
      be_4    <= be_3;

      s_5     <= sat_sample(p_4[33:15]);
      am_en_5 <= am_en_4;
      gain_5  <= gain_4;
      be_5    <= be_4;

      q_6     <= s_5 * gain_5;
      s_6     <= s_5;
      am_en_6 <= am_en_5;
      be_6    <= be_5;

      sample        <= am_en_6 ? sat_sample({{2{q_6[31]}}, q_6[31:15]}) : s_6;
      block_end_out <= be_6;
    end
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable({v1, v2, v3, v4, v5, v6})) else $error("pipeline moved while stalled");
  a_last_to_out: assert property (@(posedge clk) disable iff (rst)
    adv && v6 |=> smp_valid) else $error("result lost at output stage");
  a_pop_enters: assert property (@(posedge clk) disable iff (rst)
    pop |=> v1) else $error("popped item not in first stage");
`endif

endmodule

// ===== hw/rtl/dds_table_oscillator_unit.sv =====
// Top level of the table oscillator: front end, queue and arithmetic back end.
//
//   channel  signals                                   direction
//   cfg      cfg_valid cfg_ready cfg_index cfg_data    in, ready out
//   req      req_valid req_stall freq_offset am_gain   in, stall out
//            block_end
//   smp      smp_valid smp_stall sample block_end_out  out, stall in
//
// One sample per cycle sustained while smp_stall is low; a request taken is written
// into the queue, then passes through the seven back-end registers (six stages
// plus the output register) before its sample shows on smp_valid.
// The phase accumulator is the only loop in the datapath and advances when a request is taken.
// rst is synchronous: clears the configuration registers, phase, queue and all valid bits.
// smp_stall freezes the back end; the queue absorbs up to four requests
// before req_stall rises. cfg_ready is always high.
module dds_table_oscillator_unit import dto_pkg::*; #(
  parameter int TABLE_BITS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic signed [31:0] freq_offset,
  input  logic signed [15:0] am_gain,
  input  logic               block_end,
  output logic               smp_valid,
  input  logic               smp_stall,
  output logic signed [15:0] sample,
  output logic               block_end_out
);

  logic               push;
  item_t              push_item;
  logic               full;
  logic               pop;
  logic               head_valid;
  item_t              head_item;
  logic signed [15:0] amplitude;

  assign cfg_ready = 1'b1;
  assign req_stall = full;

  dto_front #(
    .TABLE_BITS (TABLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .req_valid   (req_valid),
    .full        (full),
    .freq_offset (freq_offset),
    .am_gain     (am_gain),
    .block_end   (block_end),
    .push        (push),
    .item        (push_item),
    .amplitude   (amplitude)
  );

  dto_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  dto_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .amplitude     (amplitude),
    .pop           (pop),
    .smp_valid     (smp_valid),
    .smp_stall     (smp_stall),
    .sample        (sample),
    .block_end_out (block_end_out)
  );

endmodule
